### hw/rtl/tape_machine_instruction_step_unit_assert.svh
// Assertion macros for the tape machine step unit.
// The including module must provide clk and rst_n.
`ifndef TAPE_MACHINE_INSTRUCTION_STEP_UNIT_ASSERT_SVH
`define TAPE_MACHINE_INSTRUCTION_STEP_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checked only while out of reset.
`define TMIS_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tape step check failed");
// Checked at every edge, reset included.
`define TMIS_CHECK_ANY(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tape step check failed");
`else
`define TMIS_CHECK(lbl, prop)
`define TMIS_CHECK_ANY(lbl, prop)
`endif

`endif

### hw/rtl/tmis_pkg.sv
package tmis_pkg;

  // Sizes
  localparam int TAPE_DEPTH    = 512;
  localparam int STACK_DEPTH   = 64;
  localparam int POSITION_BITS = 16;
  localparam int Q_DEPTH       = 2;

  localparam int TAPE_AW   = $clog2(TAPE_DEPTH);
  localparam int STACK_AW  = $clog2(STACK_DEPTH);
  localparam int STACK_CW  = $clog2(STACK_DEPTH + 1);
  localparam int SKIP_W    = 16;
  localparam int OUT_POS_W = 16;
  localparam int STATUS_W  = 3;

  // Command characters
  localparam logic [7:0] CH_RIGHT = 8'h3E;  // >
  localparam logic [7:0] CH_LEFT  = 8'h3C;  // <
  localparam logic [7:0] CH_INC   = 8'h2B;  // +
  localparam logic [7:0] CH_DEC   = 8'h2D;  // -
  localparam logic [7:0] CH_OUT   = 8'h2E;  // .
  localparam logic [7:0] CH_IN    = 8'h2C;  // ,
  localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RIGHT,
    OP_LEFT,
    OP_INC,
    OP_DEC,
    OP_OUT,
    OP_IN,
    OP_OPEN,
    OP_CLOSE
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_UNDER     = 3'd1,
    STAT_OVER      = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_UNMATCHED = 3'd4,
    STAT_BADIN     = 3'd5
  } status_t;

  // Decoded command as held in the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] value;
    logic       invalid;
  } q_entry_t;

  // Front to back: head of queue
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } fb_head_t;

  // Back to front: queue control
  typedef struct packed {
    logic pop;
    logic hold;
  } bf_ctl_t;

endpackage

### hw/rtl/tmis_ram.sv
module tmis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/tmis_front.sv
module tmis_front import tmis_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_instruction,
  input  logic [7:0] in_input_value,
  input  logic       in_input_invalid,
  input  bf_ctl_t    ctl,
  output fb_head_t   head
);

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);
  localparam logic [QAW-1:0] Q_LAST = QAW'(Q_DEPTH - 1);
  localparam logic [QCW-1:0] Q_FULL = QCW'(Q_DEPTH);

  function automatic op_t decode(input logic [7:0] ch);
    op_t op;
    unique case (ch)
      CH_RIGHT: op = OP_RIGHT;
      CH_LEFT:  op = OP_LEFT;
      CH_INC:   op = OP_INC;
      CH_DEC:   op = OP_DEC;
      CH_OUT:   op = OP_OUT;
      CH_IN:    op = OP_IN;
      CH_OPEN:  op = OP_OPEN;
      CH_CLOSE: op = OP_CLOSE;
      default:  op = OP_NOP;
    endcase
    return op;
  endfunction

  q_entry_t       q_r [Q_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push;
  logic           pop;
  q_entry_t       new_entry;

  assign in_stall = (cnt_r == Q_FULL) || ctl.hold;
  assign push     = in_valid && !in_stall;
  assign pop      = ctl.pop && (cnt_r != '0);

  assign new_entry.op      = decode(in_instruction);
  assign new_entry.value   = in_input_value;
  assign new_entry.invalid = in_input_invalid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == Q_LAST) ? '0 : wp_r + QAW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == Q_LAST) ? '0 : rp_r + QAW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= new_entry;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.entry = q_r[rp_r];

endmodule

### hw/rtl/tmis_back.sv
module tmis_back import tmis_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fb_head_t             head,
  output bf_ctl_t              ctl,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_POS_W-1:0] out_next_position,
  output logic                 out_out_valid,
  output logic [7:0]           out_out_byte,
  output logic [STATUS_W-1:0]  out_status
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_READ,
    S_EXEC
  } state_t;

  localparam logic [TAPE_AW-1:0]       TAPE_LAST = TAPE_AW'(TAPE_DEPTH - 1);
  localparam logic [STACK_CW-1:0]      STACK_MAX = STACK_CW'(STACK_DEPTH);
  localparam logic [SKIP_W-1:0]        SKIP_MAX  = '1;

  state_t                   state_r, state_nxt;
  logic [TAPE_AW-1:0]       ptr_r, ptr_nxt;
  logic [STACK_CW-1:0]      cnt_r, cnt_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [SKIP_W-1:0]        skip_r, skip_nxt;
  logic [TAPE_AW-1:0]       clr_r, clr_nxt;
  q_entry_t                 cmd_r, cmd_nxt;
  logic                     ovld_r, ovld_nxt;
  logic [OUT_POS_W-1:0]     opos_r, opos_nxt;
  logic                     oflag_r, oflag_nxt;
  logic [7:0]               obyte_r, obyte_nxt;
  status_t                  ostat_r, ostat_nxt;

  // memory ports
  logic                     tape_we, tape_re;
  logic [TAPE_AW-1:0]       tape_waddr;
  logic [7:0]               tape_wdata, cell_rd;
  logic                     stk_we, stk_re;
  logic [STACK_CW-1:0]      cnt_m1;
  logic [POSITION_BITS-1:0] stk_rdata;

  // execute results
  logic [POSITION_BITS-1:0] x_next;
  logic [TAPE_AW-1:0]       x_ptr;
  logic [STACK_CW-1:0]      x_cnt;
  logic [SKIP_W-1:0]        x_skip;
  status_t                  x_status;
  logic                     x_oflag;
  logic [7:0]               x_obyte;
  logic                     x_cell_we;
  logic [7:0]               x_cell;
  logic                     x_push;
  logic                     slot_free;

  assign cnt_m1    = cnt_r - STACK_CW'(1);
  assign slot_free = !ovld_r || !out_stall;

  always_comb begin : exec_alu
    x_next    = pos_r + POSITION_BITS'(1);
    x_ptr     = ptr_r;
    x_cnt     = cnt_r;
    x_skip    = skip_r;
    x_status  = STAT_OK;
    x_oflag   = 1'b0;
    x_obyte   = '0;
    x_cell_we = 1'b0;
    x_cell    = cell_rd;
    x_push    = 1'b0;
    if (skip_r != '0) begin
      if (cmd_r.op == OP_OPEN) begin
        if (skip_r != SKIP_MAX) begin
          x_skip = skip_r + SKIP_W'(1);
        end
      end else if (cmd_r.op == OP_CLOSE) begin
        x_skip = skip_r - SKIP_W'(1);
      end
    end else begin
      unique case (cmd_r.op)
        OP_RIGHT: begin
          if (ptr_r == TAPE_LAST) begin
            x_status = STAT_OVER;
          end else begin
            x_ptr = ptr_r + TAPE_AW'(1);
          end
        end
        OP_LEFT: begin
          if (ptr_r == '0) begin
            x_status = STAT_UNDER;
          end else begin
            x_ptr = ptr_r - TAPE_AW'(1);
          end
        end
        OP_INC: begin
          x_cell_we = 1'b1;
          x_cell    = cell_rd + 8'd1;
        end
        OP_DEC: begin
          x_cell_we = 1'b1;
          x_cell    = cell_rd - 8'd1;
        end
        OP_OUT: begin
          x_oflag = 1'b1;
          x_obyte = cell_rd;
        end
        OP_IN: begin
          if (cmd_r.invalid) begin
            x_status = STAT_BADIN;
          end else begin
            x_cell_we = 1'b1;
            x_cell    = cmd_r.value;
          end
        end
        OP_OPEN: begin
          if (cell_rd == '0) begin
            x_skip = SKIP_W'(1);
          end else if (cnt_r >= STACK_MAX) begin
            x_status = STAT_FULL;
          end else begin
            x_push = 1'b1;
            x_cnt  = cnt_r + STACK_CW'(1);
          end
        end
        OP_CLOSE: begin
          if (cnt_r == '0) begin
            x_status = STAT_UNMATCHED;
          end else if (cell_rd == '0) begin
            x_cnt = cnt_m1;
          end else begin
            x_next = stk_rdata + POSITION_BITS'(1);
          end
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin : sequencer
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    skip_nxt   = skip_r;
    clr_nxt    = clr_r;
    cmd_nxt    = cmd_r;
    ovld_nxt   = ovld_r && out_stall;
    opos_nxt   = opos_r;
    oflag_nxt  = oflag_r;
    obyte_nxt  = obyte_r;
    ostat_nxt  = ostat_r;
    tape_we    = 1'b0;
    tape_waddr = ptr_r;
    tape_wdata = x_cell;
    tape_re    = 1'b0;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    ctl.pop    = 1'b0;
    ctl.hold   = (state_r == S_CLEAR);
    unique case (state_r)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_r;
        tape_wdata = '0;
        clr_nxt    = clr_r + TAPE_AW'(1);
        if (clr_r == TAPE_LAST) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (head.valid) begin
          ctl.pop   = 1'b1;
          tape_re   = 1'b1;
          stk_re    = 1'b1;
          cmd_nxt   = head.entry;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          tape_we   = x_cell_we;
          stk_we    = x_push;
          ptr_nxt   = x_ptr;
          cnt_nxt   = x_cnt;
          pos_nxt   = x_next;
          skip_nxt  = x_skip;
          ovld_nxt  = 1'b1;
          opos_nxt  = OUT_POS_W'(x_next);
          oflag_nxt = x_oflag;
          obyte_nxt = x_obyte;
          ostat_nxt = x_status;
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r   <= '0;
      cnt_r   <= '0;
      pos_r   <= '0;
      skip_r  <= '0;
      clr_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      clr_r   <= clr_nxt;
      ovld_r  <= ovld_nxt;
    end
    cmd_r   <= cmd_nxt;
    opos_r  <= opos_nxt;
    oflag_r <= oflag_nxt;
    obyte_r <= obyte_nxt;
    ostat_r <= ostat_nxt;
  end

  tmis_ram #(
    .WIDTH (8),
    .DEPTH (TAPE_DEPTH)
  ) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .re    (tape_re),
    .raddr (ptr_r),
    .rdata (cell_rd)
  );

  tmis_ram #(
    .WIDTH (POSITION_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (cnt_r[STACK_AW-1:0]),
    .wdata (pos_r),
    .re    (stk_re),
    .raddr (cnt_m1[STACK_AW-1:0]),
    .rdata (stk_rdata)
  );

  assign out_valid         = ovld_r;
  assign out_next_position = opos_r;
  assign out_out_valid     = oflag_r;
  assign out_out_byte      = obyte_r;
  assign out_status        = ostat_r;

endmodule

### hw/rtl/tape_machine_instruction_step_unit.sv
// Tape machine instruction step unit: runs one command of the eight-command
// tape language per beat and returns one result beat per command beat.
// Input channel (in_*): the program character at the current position plus
// the byte and its invalid flag for the read command. Result channel (out_*):
// next program position to fetch, output byte with its flag, and status.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A command passes the queue, the tape read and the execute step; its result
// is registered. The executer takes no new command until the last is done, as
// the tape is read-modify-written through the single-port read of the tape RAM:
// each command must see the cell left by the one before.
// A two-beat queue lets the host keep sending while the executer works or the
// result waits. When out_stall is high the result holds and the executer
// waits; the queue then fills and in_stall rises.
// Reset: a clearing pass zeroes the tape, one cell per cycle; in_stall
// stays high throughout. Pointer, loop count, position and skip depth reset
// to zero; the loop stack is not cleared.
`include "tape_machine_instruction_step_unit_assert.svh"

module tape_machine_instruction_step_unit import tmis_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // command beats
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_instruction,
  input  logic [7:0]           in_input_value,
  input  logic                 in_input_invalid,
  // result beats
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_POS_W-1:0] out_next_position,
  output logic                 out_out_valid,
  output logic [7:0]           out_out_byte,
  output logic [STATUS_W-1:0]  out_status
);

  fb_head_t head;   // queue head to executer
  bf_ctl_t  ctl;    // pop and hold back to the queue

  // front: decode and queue
  tmis_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_instruction   (in_instruction),
    .in_input_value   (in_input_value),
    .in_input_invalid (in_input_invalid),
    .ctl              (ctl),
    .head             (head)
  );

  // back: tape, stack and result register
  tmis_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .ctl               (ctl),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_next_position (out_next_position),
    .out_out_valid     (out_out_valid),
    .out_out_byte      (out_out_byte),
    .out_status        (out_status)
  );

  // first cycle out of reset is inside the clearing pass
  `TMIS_CHECK_ANY(a_stall_after_reset, (rst_n && !$past(rst_n)) |-> in_stall)
  // an output byte only comes with a clean status
  `TMIS_CHECK(a_byte_ok, (out_valid && out_out_valid) |-> (out_status == STAT_OK))
  // the byte field is zero unless flagged
  `TMIS_CHECK(a_byte_zero, (out_valid && !out_out_valid) |-> (out_out_byte == 8'd0))

endmodule
